>>> rtl/spq_pkg.sv
// shared constants, types and codes of the stable priority queue unit
// used by every other file of the block; depends on nothing
`default_nettype none

package spq_pkg;

   localparam int DEPTH     = 64;
   localparam int ID_BITS   = 16;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   localparam int CMD_BITS  = 2;
   localparam int EID_BITS  = 16;
   localparam int PRI_BITS  = 4;
   localparam int STS_BITS  = 2;
   localparam int OCC_BITS  = 7;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_PEEK    = 2'd2
   } cmd_type;

   typedef enum logic [STS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      CTL_IDLE,
      CTL_HOLD
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       insert;
      logic       remove;
      logic       show_head;
      status_type status;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/spq_if.sv
// valid/ready channel interfaces for command and result transactions
// depends on spq_pkg for field widths
`default_nettype none

interface spq_req_if;
   logic                          valid;
   logic                          ready;
   logic [spq_pkg::CMD_BITS-1:0]  command;
   logic [spq_pkg::EID_BITS-1:0]  entry_id;
   logic [spq_pkg::PRI_BITS-1:0]  entry_priority;

   modport source (output valid, command, entry_id, entry_priority, input ready);
   modport sink   (input valid, command, entry_id, entry_priority, output ready);
endinterface

interface spq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [spq_pkg::STS_BITS-1:0]  status;
   logic [spq_pkg::EID_BITS-1:0]  head_id;
   logic [spq_pkg::PRI_BITS-1:0]  head_priority;
   logic [spq_pkg::OCC_BITS-1:0]  occupancy;

   modport source (output valid, status, head_id, head_priority, occupancy, input ready);
   modport sink   (input valid, status, head_id, head_priority, occupancy, output ready);
endinterface

`default_nettype wire

>>> rtl/stable_priority_queue_unit.sv
// top level of the stable priority queue: command and result channels
// depends on spq_pkg, spq_if, spq_controller and spq_datapath
`default_nettype none

// Bounded stable priority queue of spq_pkg::DEPTH entries (64 here). Each command
// transaction on req_chan is enqueue, dequeue or peek, and gives exactly one result
// transaction on rsp_chan with status, the head entry for dequeue and peek, and the
// occupancy after the command. Enqueue puts an entry behind every stored entry of
// lower or equal priority value, so smaller values leave first and ties leave in
// arrival order; an enqueue on a full queue is refused with the full status and
// dequeue or peek on an empty one report empty. On acceptance the sorted row of
// entries compares every slot against the new priority and shifts at once, and the
// result is registered and offered in the cycle after acceptance. One command
// per cycle is sustained while rsp_chan is taken each cycle, since the result
// register is freed in the cycle its transaction completes. Reset empties the queue
// through the fill count; slot contents are not cleared.
module stable_priority_queue_unit (
   input  wire logic clock,
   input  wire logic reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   spq_pkg::ctl_cmd_type   cmd;        // one-cycle operation request
   spq_pkg::dp_status_type dp_status;  // empty / full flags from the fill count

   // handshake and decode
   spq_controller u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_command (req_chan.command),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .dp_status   (dp_status),
      .cmd         (cmd)
   );

   // sorted storage row and result register
   spq_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .entry_id          (req_chan.entry_id),
      .entry_priority    (req_chan.entry_priority),
      .dp_status         (dp_status),
      .rsp_status        (rsp_chan.status),
      .rsp_head_id       (rsp_chan.head_id),
      .rsp_head_priority (rsp_chan.head_priority),
      .rsp_occupancy     (rsp_chan.occupancy)
   );

endmodule

`default_nettype wire

>>> rtl/spq_datapath.sv
// sorted compare-and-shift row of entries, fill count and result register
// depends on spq_pkg; driven by spq_controller commands
`default_nettype none

module spq_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire spq_pkg::ctl_cmd_type          cmd,
   input  wire logic [spq_pkg::EID_BITS-1:0]  entry_id,
   input  wire logic [spq_pkg::PRI_BITS-1:0]  entry_priority,
   output spq_pkg::dp_status_type             dp_status,
   output logic [spq_pkg::STS_BITS-1:0]       rsp_status,
   output logic [spq_pkg::EID_BITS-1:0]       rsp_head_id,
   output logic [spq_pkg::PRI_BITS-1:0]       rsp_head_priority,
   output logic [spq_pkg::OCC_BITS-1:0]       rsp_occupancy
);

   logic [spq_pkg::ID_BITS-1:0]   slot_id_ff  [spq_pkg::DEPTH];
   logic [spq_pkg::ID_BITS-1:0]   slot_id_in  [spq_pkg::DEPTH];
   logic [spq_pkg::PRI_BITS-1:0]  slot_pri_ff [spq_pkg::DEPTH];
   logic [spq_pkg::PRI_BITS-1:0]  slot_pri_in [spq_pkg::DEPTH];
   logic [spq_pkg::CNT_BITS-1:0]  count_ff;
   logic [spq_pkg::CNT_BITS-1:0]  count_in;
   logic [spq_pkg::DEPTH-1:0]     stays_ahead;
   logic [spq_pkg::ID_BITS-1:0]   new_id;

   logic [spq_pkg::STS_BITS-1:0]  status_ff;
   logic [spq_pkg::EID_BITS-1:0]  head_id_ff;
   logic [spq_pkg::PRI_BITS-1:0]  head_pri_ff;
   logic [spq_pkg::OCC_BITS-1:0]  occ_ff;

   assign new_id = spq_pkg::ID_BITS'(entry_id);

   for (genvar k = 0; k < spq_pkg::DEPTH; k++) begin : g_cell
      // stored entry that the new one queues behind
      assign stays_ahead[k] = (spq_pkg::CNT_BITS'(k) < count_ff)
                              && (slot_pri_ff[k] <= entry_priority);

      always_comb begin
         slot_id_in[k]  = slot_id_ff[k];
         slot_pri_in[k] = slot_pri_ff[k];
         if (cmd.insert) begin
            if (k == 0) begin
               if (!stays_ahead[0]) begin
                  slot_id_in[k]  = new_id;
                  slot_pri_in[k] = entry_priority;
               end
            end else if (!stays_ahead[(k > 0) ? k - 1 : 0]) begin
               slot_id_in[k]  = slot_id_ff[(k > 0) ? k - 1 : 0];
               slot_pri_in[k] = slot_pri_ff[(k > 0) ? k - 1 : 0];
            end else if (!stays_ahead[k]) begin
               slot_id_in[k]  = new_id;
               slot_pri_in[k] = entry_priority;
            end
         end else if (cmd.remove && (k < spq_pkg::DEPTH - 1)) begin
            slot_id_in[k]  = slot_id_ff[(k < spq_pkg::DEPTH - 1) ? k + 1 : k];
            slot_pri_in[k] = slot_pri_ff[(k < spq_pkg::DEPTH - 1) ? k + 1 : k];
         end
      end
   end

   assign count_in = count_ff + spq_pkg::CNT_BITS'(cmd.insert)
                     - spq_pkg::CNT_BITS'(cmd.remove);

   assign dp_status.empty = (count_ff == '0);
   assign dp_status.full  = (count_ff >= spq_pkg::CNT_BITS'(spq_pkg::DEPTH));

   always_ff @(posedge clock) begin
      slot_id_ff  <= slot_id_in;
      slot_pri_ff <= slot_pri_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff   <= cmd.status;
         head_id_ff  <= cmd.show_head ? spq_pkg::EID_BITS'(slot_id_ff[0]) : '0;
         head_pri_ff <= cmd.show_head ? slot_pri_ff[0] : '0;
         occ_ff      <= spq_pkg::OCC_BITS'(count_in);
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_head_id       = head_id_ff;
   assign rsp_head_priority = head_pri_ff;
   assign rsp_occupancy     = occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::CNT_BITS'(spq_pkg::DEPTH))
      else $error("fill count above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == $past(count_ff) + spq_pkg::CNT_BITS'(1))
      else $error("insert did not grow the queue by one");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> count_ff == $past(count_ff) - spq_pkg::CNT_BITS'(1))
      else $error("remove did not shrink the queue by one");

endmodule

`default_nettype wire

>>> rtl/spq_controller.sv
// handshake state machine and command decode for the queue
// depends on spq_pkg; steers spq_datapath through a command struct
`default_nettype none

module spq_controller (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [spq_pkg::CMD_BITS-1:0]  req_command,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire spq_pkg::dp_status_type        dp_status,
   output spq_pkg::ctl_cmd_type               cmd
);

   spq_pkg::state_type state_ff;
   spq_pkg::state_type state_in;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spq_pkg::CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      // the result register frees up in the same cycle it is taken
      req_ready = (state_ff == spq_pkg::CTL_IDLE) || rsp_ready;
      rsp_valid = (state_ff == spq_pkg::CTL_HOLD);
      accept    = req_valid && req_ready;

      state_in = state_ff;
      case (state_ff)
         spq_pkg::CTL_IDLE: begin
            if (accept) state_in = spq_pkg::CTL_HOLD;
         end
         spq_pkg::CTL_HOLD: begin
            if (!accept && rsp_ready) state_in = spq_pkg::CTL_IDLE;
         end
         default: state_in = spq_pkg::CTL_IDLE;
      endcase

      cmd           = '0;
      cmd.status    = spq_pkg::ST_OK;
      cmd.load      = accept;
      case (req_command)
         spq_pkg::CMD_ENQUEUE: begin
            if (dp_status.full) begin
               cmd.status = spq_pkg::ST_FULL;
            end else begin
               cmd.insert = accept;
            end
         end
         spq_pkg::CMD_DEQUEUE: begin
            if (dp_status.empty) begin
               cmd.status = spq_pkg::ST_EMPTY;
            end else begin
               cmd.remove    = accept;
               cmd.show_head = 1'b1;
            end
         end
         spq_pkg::CMD_PEEK: begin
            if (dp_status.empty) begin
               cmd.status = spq_pkg::ST_EMPTY;
            end else begin
               cmd.show_head = 1'b1;
            end
         end
         default: ;  // unused code: ok result, nothing changes
      endcase
   end

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted command produced no result");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |-> !dp_status.empty)
      else $error("remove issued on empty queue");

   a_single_op: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && cmd.remove) && (!cmd.insert || !dp_status.full))
      else $error("conflicting or overflowing queue operation");

endmodule

`default_nettype wire

>>> tb/spq_order_checker.sv
`timescale 1ns / 100ps
// service-order checker for the stable priority queue unit: watches both channels,
// predicts every result and compares it; depends on spq_pkg and spq_if
module spq_order_checker
   import spq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   spq_req_if   req_chan,
   spq_rsp_if   rsp_chan,
   output int   fail_count,
   output int   pending_count,
   output int   result_count,
   output int   full_count,
   output int   empty_count,
   output int   peak_fill
);

   localparam logic [EID_BITS-1:0] ID_MASK =
      (ID_BITS >= EID_BITS) ? {EID_BITS{1'b1}} : EID_BITS'((64'd1 << ID_BITS) - 1);

   typedef struct packed {
      status_type            status;
      logic [EID_BITS-1:0]   head_id;
      logic [PRI_BITS-1:0]   head_priority;
      logic [OCC_BITS-1:0]   occupancy;
   } queue_result_t;

   // entries in service order, head at index 0
   logic [EID_BITS-1:0] slot_id  [DEPTH];
   logic [PRI_BITS-1:0] slot_pri [DEPTH];
   int                  fill;

   queue_result_t awaited_results[$];
   queue_result_t want;
   queue_result_t got;

   function automatic queue_result_t predict_command(input logic [CMD_BITS-1:0] cmd,
                                                     input logic [EID_BITS-1:0] id,
                                                     input logic [PRI_BITS-1:0] pri);
      queue_result_t res;
      int            pos;
      res = '{status: ST_OK, head_id: '0, head_priority: '0, occupancy: '0};
      case (cmd)
         CMD_ENQUEUE: begin
            if (fill >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // behind every entry of lower or equal value
               pos = 0;
               while (pos < fill && slot_pri[pos] <= pri) pos++;
               for (int k = fill; k > pos; k--) begin
                  slot_id[k]  = slot_id[k-1];
                  slot_pri[k] = slot_pri[k-1];
               end
               slot_id[pos]  = id & ID_MASK;
               slot_pri[pos] = pri;
               fill++;
            end
         end
         CMD_DEQUEUE, CMD_PEEK: begin
            if (fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.head_id       = slot_id[0];
               res.head_priority = slot_pri[0];
               if (cmd == CMD_DEQUEUE) begin
                  for (int k = 1; k < fill; k++) begin
                     slot_id[k-1]  = slot_id[k];
                     slot_pri[k-1] = slot_pri[k];
                  end
                  fill--;
               end
            end
         end
         default: ;
      endcase
      res.occupancy = OCC_BITS'(fill);
      return res;
   endfunction

   initial begin
      fail_count    = 0;
      pending_count = 0;
      result_count  = 0;
      full_count    = 0;
      empty_count   = 0;
      peak_fill     = 0;
      fill          = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         fill = 0;
         awaited_results.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            result_count++;
            got = '{status: status_type'(rsp_chan.status), head_id: rsp_chan.head_id,
                    head_priority: rsp_chan.head_priority, occupancy: rsp_chan.occupancy};
            if (awaited_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with nothing awaited: status %0d id %h pri %0d occ %0d",
                           $time, got.status, got.head_id, got.head_priority, got.occupancy);
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status || got.head_id !== want.head_id ||
                   got.head_priority !== want.head_priority ||
                   got.occupancy !== want.occupancy) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch: expected status %0d id %h pri %0d occ %0d, ",
                               "got status %0d id %h pri %0d occ %0d"}, $time,
                              want.status, want.head_id, want.head_priority, want.occupancy,
                              got.status, got.head_id, got.head_priority, got.occupancy);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            want = predict_command(req_chan.command, req_chan.entry_id,
                                   req_chan.entry_priority);
            if (want.status == ST_FULL) full_count++;
            if (want.status == ST_EMPTY) empty_count++;
            if (fill > peak_fill) peak_fill = fill;
            awaited_results.push_back(want);
         end
      end
      pending_count = awaited_results.size();
   end

endmodule

>>> tb/tb_stable_priority_queue_unit.sv
`timescale 1ns / 100ps
// testbench top for the stable priority queue unit: clock, reset, command stimulus,
// result back-pressure and verdict; depends on spq_pkg, spq_if and spq_order_checker
module tb_stable_priority_queue_unit;
   import spq_pkg::*;

   // command code the block must treat as a no-op
   localparam logic [CMD_BITS-1:0] CMD_UNUSED  = 2'd3;
   localparam int                  RANDOM_CMDS = 900;
   localparam int                  CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;

   spq_req_if req_chan ();
   spq_rsp_if rsp_chan ();

   int fail_count;
   int pending_count;
   int result_count;
   int full_count;
   int empty_count;
   int peak_fill;

   // stimulus-side bookkeeping: rough fill level to shape the phases
   int level;
   int sent_count;
   int burst_left;
   int cycle_count;

   // receiver stall pattern state
   int stall_mode;
   int stall_cycle;
   int hold_left;

   stable_priority_queue_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   spq_order_checker i_order_check (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .full_count    (full_count),
      .empty_count   (empty_count),
      .peak_fill     (peak_fill)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog, generous against the slowest legal run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited",
                  cycle_count, pending_count);
         $display("** stable_priority_queue_unit: FAILED **");
         $finish;
      end
   end

   // result back-pressure: the mode is redrawn at random from a stall counter; mode 0
   // stalls only to finish a hold, the others stall at random, in long holds or on a fixed beat
   initial begin
      rsp_chan.ready = 1'b0;
      stall_mode     = 0;
      stall_cycle    = 0;
      hold_left      = 0;
   end

   always @(negedge clock) begin
      stall_cycle++;
      if (stall_cycle % 150 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            2: begin
               if ($urandom_range(0, 15) == 0) begin
                  hold_left = $urandom_range(2, 12);
                  rsp_chan.ready <= 1'b0;
               end else begin
                  rsp_chan.ready <= 1'b1;
               end
            end
            default: rsp_chan.ready <= ((stall_cycle % 5) > 1);
         endcase
      end
   end

   // one command transaction; the sender runs in bursts with random gaps, a gap
   // of zero keeps valid high straight into the next burst
   task automatic issue(input logic [CMD_BITS-1:0] cmd,
                        input logic [EID_BITS-1:0] id,
                        input logic [PRI_BITS-1:0] pri);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid          <= 1'b1;
      req_chan.command        <= cmd;
      req_chan.entry_id       <= id;
      req_chan.entry_priority <= pri;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sent_count++;
      if (cmd == CMD_ENQUEUE && level < DEPTH) level++;
      if (cmd == CMD_DEQUEUE && level > 0) level--;
   endtask

   // sender holds off until every awaited result has come back
   task automatic settle_queue();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   function automatic logic [EID_BITS-1:0] any_id();
      return EID_BITS'($urandom_range(0, (1 << EID_BITS) - 1));
   endfunction

   function automatic logic [PRI_BITS-1:0] any_pri();
      return PRI_BITS'($urandom_range(0, (1 << PRI_BITS) - 1));
   endfunction

   initial begin
      int random_sent;
      int phase;
      int n;
      int r;
      logic [PRI_BITS-1:0] tie_a;
      logic [PRI_BITS-1:0] tie_b;

      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.command        = CMD_ENQUEUE;
      req_chan.entry_id       = '0;
      req_chan.entry_priority = '0;
      level                   = 0;
      sent_count              = 0;
      burst_left              = 0;
      random_sent             = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty reports, the no-op code, id and priority extremes, ties
      issue(CMD_DEQUEUE, '0, '0);
      issue(CMD_PEEK, '0, '0);
      issue(CMD_UNUSED, 16'hFFFF, 4'hF);
      issue(CMD_ENQUEUE, 16'hFFFF, 4'd15);
      issue(CMD_ENQUEUE, 16'h0000, 4'd0);
      issue(CMD_PEEK, 16'hFFFF, 4'hF);
      issue(CMD_ENQUEUE, 16'h1234, 4'd7);
      issue(CMD_ENQUEUE, 16'hA5A5, 4'd7);
      issue(CMD_ENQUEUE, 16'h5A5A, 4'd7);
      issue(CMD_ENQUEUE, 16'h8001, 4'd0);
      issue(CMD_ENQUEUE, 16'h7FFE, 4'd15);
      // no-op with entries stored: occupancy must hold
      issue(CMD_UNUSED, 16'h0000, 4'h0);
      issue(CMD_PEEK, '0, '0);
      repeat (7) issue(CMD_DEQUEUE, '0, '0);
      issue(CMD_DEQUEUE, 16'hFFFF, 4'hF);
      issue(CMD_PEEK, '0, '0);
      settle_queue();

      // random part: fill past full first, then mixed phases
      phase = 0;
      while (random_sent < RANDOM_CMDS) begin
         case (phase)
            0, 1: begin
               // fill to the top and knock on a full queue a few times
               n = DEPTH - level + $urandom_range(1, 3);
               repeat (n) issue(CMD_ENQUEUE, any_id(), any_pri());
            end
            2: begin
               // drain to empty, with peeks along the way and a few extra
               n = level + $urandom_range(1, 2);
               repeat (n) begin
                  if ($urandom_range(0, 5) == 0) issue(CMD_PEEK, any_id(), any_pri());
                  issue(CMD_DEQUEUE, any_id(), any_pri());
               end
            end
            3: begin
               // many equal priorities: arrival order must survive
               n     = $urandom_range(4, 16);
               tie_a = any_pri();
               tie_b = any_pri();
               repeat (n) issue(CMD_ENQUEUE, any_id(), $urandom_range(0, 1) ? tie_a : tie_b);
               repeat ($urandom_range(2, n)) issue(CMD_DEQUEUE, any_id(), any_pri());
            end
            default: begin
               n = $urandom_range(10, 40);
               repeat (n) begin
                  r = $urandom_range(0, 99);
                  if (level > DEPTH - 8) r = r + 20;
                  if (r < 45)       issue(CMD_ENQUEUE, any_id(), any_pri());
                  else if (r < 85)  issue(CMD_DEQUEUE, any_id(), any_pri());
                  else if (r < 115) issue(CMD_PEEK, any_id(), any_pri());
                  else              issue(CMD_UNUSED, any_id(), any_pri());
               end
            end
         endcase
         random_sent += n;
         if (phase == 0 || $urandom_range(0, 4) == 0) settle_queue();
         phase = $urandom_range(1, 9);
      end

      // wait out the last results
      settle_queue();
      repeat (5) @(negedge clock);

      $display("covered %0d commands and %0d results, deepest fill %0d of %0d",
               sent_count, result_count, peak_fill, DEPTH);
      $display("%0d enqueues refused as full, %0d dequeue or peek on empty",
               full_count, empty_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** stable_priority_queue_unit: PASSED **");
      end else begin
         $display("** stable_priority_queue_unit: FAILED **");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_datapath.sv
rtl/spq_controller.sv
rtl/stable_priority_queue_unit.sv
tb/spq_order_checker.sv
tb/tb_stable_priority_queue_unit.sv
